/* sv/mh64_pkg.sv */
// Shared types, constants and mix functions for the 64-bit streaming hash.
// No dependencies; imported by the front, queue, back and top level.
package mh64_pkg;

    localparam logic [63:0] SEED_CONST = 64'hde79d3747be356ce;
    localparam int          MIX_STEPS  = 12;
    localparam int          STEP_W     = 4;
    localparam int          BLOCK_BYTES = 32;

    typedef logic [3:0][63:0] t_lanes;

    // How the back end must treat a queued item
    typedef enum logic [1:0] {
        K_BLOCK  = 2'd0,   // inner block: add all four words, mix
        K_LAST32 = 2'd1,   // last item with a full block
        K_LAST16 = 2'd2,   // last item with 16..31 bytes
        K_SHORT  = 2'd3    // last item with 0..15 bytes
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic        seed_en;
        logic [63:0] seed;
        t_lanes      words;   // on a last item, bytes past the count already zeroed
    } t_entry;

    function automatic logic [5:0] rot_amt(input logic [STEP_W-1:0] step);
        logic [5:0] r;
        case (step)
            4'd0:    r = 6'd50;
            4'd1:    r = 6'd52;
            4'd2:    r = 6'd30;
            4'd3:    r = 6'd41;
            4'd4:    r = 6'd54;
            4'd5:    r = 6'd48;
            4'd6:    r = 6'd38;
            4'd7:    r = 6'd37;
            4'd8:    r = 6'd62;
            4'd9:    r = 6'd34;
            4'd10:   r = 6'd5;
            4'd11:   r = 6'd36;
            default: r = 6'd0;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] n);
        logic [127:0] t;
        t = {x, x} << n;
        return t[127:64];
    endfunction

    // One rotate/add/xor step of the mix round; lanes cycle c,d,a,b
    function automatic t_lanes mix_step(input t_lanes l, input logic [STEP_W-1:0] step);
        t_lanes      r;
        logic [1:0]  k;
        logic [1:0]  xi;
        logic [1:0]  yi;
        logic [63:0] x;
        r  = l;
        k  = step[1:0];
        xi = k + 2'd2;
        yi = k + 2'd3;
        x  = rotl64(l[xi], rot_amt(step)) + l[yi];
        r[xi] = x;
        r[k]  = l[k] ^ x;
        return r;
    endfunction

endpackage

/* sv/mh64_if.sv */
// Valid/ready channel interfaces for the hash input items and hash results.
// Depends on nothing; used by the top level and the front and back ends.
interface mh64_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] word0;
    logic [63:0] word1;
    logic [63:0] word2;
    logic [63:0] word3;
    logic [5:0]  byte_count;
    logic        last_item;
    logic [31:0] message_length;

    modport source (output valid, word0, word1, word2, word3, byte_count, last_item,
                    message_length, input ready);
    modport sink   (input valid, word0, word1, word2, word3, byte_count, last_item,
                    message_length, output ready);
endinterface

interface mh64_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] hash_value;

    modport source (output valid, hash_value, input ready);
    modport sink   (input valid, hash_value, output ready);
endinterface

/* sv/mh64_front.sv */
// Front end: accepts input items, tracks message boundaries, masks tail bytes
// and classifies each item for the back end. Uses mh64_pkg and mh64_in_if.
module mh64_front
    import mh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    mh64_in_if.sink     i_in,
    output logic        o_push_valid,
    input  logic        i_push_ready,
    output t_entry      o_push_entry
);

    logic       r_in_message;
    logic       n_in_message;
    logic [5:0] count;
    logic [BLOCK_BYTES*8-1:0] raw;
    logic [BLOCK_BYTES*8-1:0] masked;
    t_kind      kind;

    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    always_comb begin
        count = (i_in.byte_count > 6'(BLOCK_BYTES)) ? 6'(BLOCK_BYTES) : i_in.byte_count;
        raw   = {i_in.word3, i_in.word2, i_in.word1, i_in.word0};
        for (int i = 0; i < BLOCK_BYTES; i++) begin
            masked[i*8 +: 8] = (!i_in.last_item || (6'(i) < count)) ? raw[i*8 +: 8] : 8'h00;
        end
        if (!i_in.last_item) begin
            kind = K_BLOCK;
        end else if (count == 6'(BLOCK_BYTES)) begin
            kind = K_LAST32;
        end else if (count >= 6'(BLOCK_BYTES / 2)) begin
            kind = K_LAST16;
        end else begin
            kind = K_SHORT;
        end
    end

    always_comb begin
        o_push_entry.kind    = kind;
        o_push_entry.seed_en = !r_in_message;
        o_push_entry.seed    = {32'h0, i_in.message_length} + SEED_CONST;
        o_push_entry.words   = masked;
    end

    always_comb begin
        n_in_message = r_in_message;
        if (i_in.valid && i_push_ready) begin
            n_in_message = !i_in.last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_message <= 1'b0;
        end else begin
            r_in_message <= n_in_message;
        end
    end

endmodule

/* sv/mh64_queue.sv */
// Short register FIFO of classified items between front and back end.
// Uses mh64_pkg for the entry type. DEPTH must be a power of two.
module mh64_queue
    import mh64_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_valid,
    output logic   o_push_ready,
    input  t_entry i_push_entry,
    output logic   o_pop_valid,
    input  logic   i_pop_ready,
    output t_entry o_pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_entry             r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_entry  = r_mem[r_rd_ptr];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

/* sv/mh64_back.sv */
// Back end: seeds and updates the four lanes, runs the mix round one step
// per cycle, sums the lanes and holds the result. Uses mh64_pkg, mh64_out_if.
module mh64_back
    import mh64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_pop_valid,
    output logic        o_pop_ready,
    input  t_entry      i_pop_entry,
    mh64_out_if.source  o_out
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MIX,
        S_ADD2,
        S_SUM1,
        S_SUM2
    } t_state;

    t_state              r_state;
    t_lanes              r_lanes;
    logic [STEP_W-1:0]   r_step;
    logic                r_final;
    logic                r_block;
    logic [1:0][63:0]    r_q;
    logic [63:0]         r_ab;
    logic [63:0]         r_cd;
    logic [63:0]         r_hash;
    logic                r_out_valid;

    t_lanes              base;

    assign o_pop_ready     = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.hash_value = r_hash;

    assign base = i_pop_entry.seed_en ? {4{i_pop_entry.seed}} : r_lanes;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_final     <= 1'b0;
            r_block     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_pop_valid) begin
                        r_step  <= '0;
                        r_state <= S_MIX;
                        r_block <= (i_pop_entry.kind == K_BLOCK);
                        unique case (i_pop_entry.kind)
                            K_BLOCK, K_LAST32: begin
                                for (int i = 0; i < 4; i++) begin
                                    r_lanes[i] <= base[i] + i_pop_entry.words[i];
                                end
                                r_q     <= '0;
                                r_final <= 1'b0;
                            end
                            K_LAST16: begin
                                r_lanes[0] <= base[0] + i_pop_entry.words[0];
                                r_lanes[1] <= base[1] + i_pop_entry.words[1];
                                r_lanes[2] <= base[2];
                                r_lanes[3] <= base[3];
                                r_q     <= {i_pop_entry.words[3], i_pop_entry.words[2]};
                                r_final <= 1'b0;
                            end
                            K_SHORT: begin
                                r_lanes[0] <= base[0];
                                r_lanes[1] <= base[1];
                                r_lanes[2] <= base[2] + i_pop_entry.words[0];
                                r_lanes[3] <= base[3] + i_pop_entry.words[1];
                                r_q     <= '0;
                                r_final <= 1'b1;
                            end
                            default: begin
                                r_final <= 1'b1;
                            end
                        endcase
                    end
                end
                S_MIX: begin
                    r_lanes <= mix_step(r_lanes, r_step);
                    if (r_step == STEP_W'(MIX_STEPS - 1)) begin
                        r_step <= '0;
                        if (r_final) begin
                            r_state <= S_SUM1;
                        end else if (r_block) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_ADD2;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_ADD2: begin
                    // tail words go to c and d before the final mix
                    r_lanes[2] <= r_lanes[2] + r_q[0];
                    r_lanes[3] <= r_lanes[3] + r_q[1];
                    r_final    <= 1'b1;
                    r_state    <= S_MIX;
                end
                S_SUM1: begin
                    r_ab    <= r_lanes[0] + r_lanes[1];
                    r_cd    <= r_lanes[2] + r_lanes[3];
                    r_state <= S_SUM2;
                end
                S_SUM2: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_hash      <= r_ab + r_cd;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/mix_hash64_stream.sv */
// Top level of the streaming 64-bit hash: front end, item queue, back end.
// Uses mh64_pkg, mh64_if, mh64_front, mh64_queue and mh64_back.
//
// Usage:
//   i_in carries message items of up to 32 bytes as four little-endian words
//   with byte_count, last_item and message_length (read on a message's first
//   item only). o_out carries one hash_value per message, after its last item.
//   A transfer happens on a rising edge with valid and ready both high.
//
// Throughput and sequencing:
//   The front end accepts an item in every cycle while the queue
//   (QUEUE_DEPTH entries) has room. The back end runs the mix round on one
//   shared rotate/add/xor unit, one step per cycle, and takes no new item
//   from the queue until it is idle again. Every item gets a mix round; a last
//   item of 16..32 bytes adds its tail and gets a second one, and a last item
//   goes through the two sum states into the result register after that.
//
// Reset (i_rst_n low, synchronous) empties the queue, drops any pending
// result and returns to awaiting the first item of a message. While the
// receiver stalls, the result is held; the queue keeps taking items until
// it fills, then i_in.ready drops. QUEUE_DEPTH must be a power of two.
module mix_hash64_stream
    import mh64_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mh64_in_if.sink     i_in,
    mh64_out_if.source  o_out
);

    logic   push_valid;
    logic   push_ready;
    t_entry push_entry;
    logic   pop_valid;
    logic   pop_ready;
    t_entry pop_entry;

    mh64_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_entry (push_entry)
    );

    mh64_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_entry (push_entry),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_entry  (pop_entry)
    );

    mh64_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_entry (pop_entry),
        .o_out       (o_out)
    );

endmodule

/* verif/mix_hash64_stream_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for mix_hash64_stream: drives messages over the input channel,
// predicts each message hash and checks every result transfer. Depends on mh64_if.
module mix_hash64_stream_tb;

    localparam logic [63:0] HASH_SEED    = 64'hde79d3747be356ce;
    localparam int          IDLE_PCT     = 32;
    localparam int          TOTAL_ITEMS  = 1570;
    localparam int          CALM_FIRST   = 700;   // sender never idles in this item range
    localparam int          CALM_LAST    = 950;
    localparam int          HOLD_START   = 3000;  // receiver hold-off, in cycles after reset
    localparam int          HOLD_CYCLES  = 400;
    localparam int          RX_CALM_LO   = 8000;  // receiver never stalls in this cycle range
    localparam int          RX_CALM_HI   = 11000;
    localparam int          DRAIN_CYCLES = 80;

    typedef struct packed {
        logic [3:0][63:0] words;
        logic [5:0]       byte_count;
        logic             last_item;
        logic [31:0]      message_length;
    } t_msg_item;

    class hash_scoreboard;
        logic [63:0] lanes [4];
        bit          in_message;
        logic [63:0] expected_hashes [$];
        int          mismatches;

        function new();
            foreach (lanes[i]) lanes[i] = '0;
            in_message = 1'b0;
            mismatches = 0;
        endfunction

        function logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
            return (x << n) | (x >> (64 - n));
        endfunction

        function void mix_round();
            logic [63:0] a, b, c, d;
            a = lanes[0]; b = lanes[1]; c = lanes[2]; d = lanes[3];
            c = rotl(c, 50) + d; a ^= c;
            d = rotl(d, 52) + a; b ^= d;
            a = rotl(a, 30) + b; c ^= a;
            b = rotl(b, 41) + c; d ^= b;
            c = rotl(c, 54) + d; a ^= c;
            d = rotl(d, 48) + a; b ^= d;
            a = rotl(a, 38) + b; c ^= a;
            b = rotl(b, 37) + c; d ^= b;
            c = rotl(c, 62) + d; a ^= c;
            d = rotl(d, 34) + a; b ^= d;
            a = rotl(a, 5)  + b; c ^= a;
            b = rotl(b, 36) + c; d ^= b;
            lanes[0] = a; lanes[1] = b; lanes[2] = c; lanes[3] = d;
        endfunction

        function logic [63:0] low_bytes(input logic [63:0] w, input int n);
            if (n >= 8) return w;
            if (n <= 0) return '0;
            return w & ((64'd1 << (8 * n)) - 64'd1);
        endfunction

        function void note_input(input t_msg_item it);
            int          cnt;
            int          rem;
            logic [63:0] t0;
            logic [63:0] t1;
            if (!in_message) begin
                foreach (lanes[i]) lanes[i] = HASH_SEED + {32'd0, it.message_length};
            end
            // inner items always count as a full block
            if (!it.last_item) begin
                foreach (lanes[i]) lanes[i] += it.words[i];
                mix_round();
                in_message = 1'b1;
                return;
            end
            cnt = (it.byte_count > 32) ? 32 : int'(it.byte_count);
            if (cnt == 32) begin
                foreach (lanes[i]) lanes[i] += it.words[i];
                mix_round();
                rem = 0; t0 = '0; t1 = '0;
            end else if (cnt >= 16) begin
                lanes[0] += it.words[0];
                lanes[1] += it.words[1];
                mix_round();
                rem = cnt - 16; t0 = it.words[2]; t1 = it.words[3];
            end else begin
                rem = cnt; t0 = it.words[0]; t1 = it.words[1];
            end
            lanes[2] += low_bytes(t0, rem);
            lanes[3] += low_bytes(t1, rem - 8);
            mix_round();
            expected_hashes.push_back(lanes[0] + lanes[1] + lanes[2] + lanes[3]);
            in_message = 1'b0;
        endfunction

        function void check_result(input logic [63:0] got);
            logic [63:0] want;
            if (expected_hashes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: hash_value %h with no message pending", $realtime, got);
                return;
            end
            want = expected_hashes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: hash_value expected %h actual %h", $realtime, want, got);
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   items_sent = 0;
    int   rx_cycles = 0;

    hash_scoreboard hash_sb = new();

    mh64_in_if  in_ch ();
    mh64_out_if out_ch ();

    mix_hash64_stream DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Sample both channels on the edge where the transfer happens
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                hash_sb.note_input({in_ch.word3, in_ch.word2, in_ch.word1, in_ch.word0,
                                    in_ch.byte_count, in_ch.last_item,
                                    in_ch.message_length});
            if (out_ch.valid && out_ch.ready)
                hash_sb.check_result(out_ch.hash_value);
        end
    end

    function automatic t_msg_item filled_item(input logic [63:0] fill, input int count,
                                              input bit last, input logic [31:0] len);
        t_msg_item it;
        it.words          = {4{fill}};
        it.byte_count     = 6'(count);
        it.last_item      = last;
        it.message_length = len;
        return it;
    endfunction

    function automatic t_msg_item random_item(input int count, input bit last,
                                              input logic [31:0] len);
        t_msg_item it;
        foreach (it.words[i]) it.words[i] = {$urandom, $urandom};
        it.byte_count     = 6'(count);
        it.last_item      = last;
        it.message_length = len;
        return it;
    endfunction

    task automatic send_item(input t_msg_item it);
        while (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST) &&
               $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.word0          <= it.words[0];
        in_ch.word1          <= it.words[1];
        in_ch.word2          <= it.words[2];
        in_ch.word3          <= it.words[3];
        in_ch.byte_count     <= it.byte_count;
        in_ch.last_item      <= it.last_item;
        in_ch.message_length <= it.message_length;
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic run_directed();
        int single_counts [13] = '{0, 1, 7, 8, 9, 15, 16, 17, 24, 31, 32, 33, 63};
        // single-item messages; all-ones words expose bytes past the count
        foreach (single_counts[i])
            send_item(filled_item('1, single_counts[i], 1'b1,
                                  (single_counts[i] == 33) ? 32'hffffffff
                                                           : 32'(single_counts[i])));
        // multi-item message; byte_count on inner items must be ignored
        send_item(filled_item('1, 0, 1'b0, 32'hffffffff));
        send_item(filled_item('1, 63, 1'b0, 32'd0));
        send_item(random_item(20, 1'b1, 32'd84));
        // length that does not match the delivered bytes
        send_item(filled_item('0, 5, 1'b0, 32'd5));
        send_item(filled_item('0, 0, 1'b1, 32'd0));
    endtask

    task automatic run_random();
        int          n_inner;
        int          last_count;
        logic [31:0] len;
        while (items_sent < TOTAL_ITEMS) begin
            n_inner    = $urandom_range(4);
            last_count = ($urandom_range(9) < 8) ? $urandom_range(32) : $urandom_range(63, 33);
            len        = ($urandom_range(3) == 0)
                         ? 32'($urandom)
                         : 32'(32 * n_inner + ((last_count > 32) ? 32 : last_count));
            for (int k = 0; k < n_inner; k++)
                send_item(random_item($urandom_range(63), 1'b0, (k == 0) ? len : 32'($urandom)));
            send_item(random_item(last_count, 1'b1, (n_inner == 0) ? len : 32'($urandom)));
        end
    endtask

    // Receiver: random stalls, one long hold-off so the input side backs up
    initial begin
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            rx_cycles++;
            if (rx_cycles >= HOLD_START && rx_cycles < HOLD_START + HOLD_CYCLES)
                out_ch.ready <= 1'b0;
            else if (rx_cycles >= RX_CALM_LO && rx_cycles < RX_CALM_HI)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        i_rst_n              <= 1'b0;
        in_ch.valid          <= 1'b0;
        in_ch.word0          <= '0;
        in_ch.word1          <= '0;
        in_ch.word2          <= '0;
        in_ch.word3          <= '0;
        in_ch.byte_count     <= '0;
        in_ch.last_item      <= 1'b0;
        in_ch.message_length <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        run_random();
        in_ch.valid <= 1'b0;
        while (hash_sb.expected_hashes.size() != 0) @(posedge i_clk);
        // catch any stray result after the last expected one
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (hash_sb.mismatches == 0 && hash_sb.expected_hashes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
